[hw/rtl/spmq_pkg.sv]
// Shared types and codes for the strict-priority multilevel queue.
`default_nettype none
package spmq_pkg;

	localparam int CMD_W  = 2;
	localparam int LVL_W  = 3;
	localparam int DATA_W = 8;
	localparam int ST_W   = 2;
	localparam int CFG_W  = 4;

	// command codes on the input side
	localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

	localparam logic [CFG_W-1:0] LEVELS_RESET = 4'd8;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_ENQ    = 2'd0,
		OP_DEQ    = 2'd1,
		OP_PEEK   = 2'd2,
		OP_REJECT = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [LVL_W-1:0]  level;
		logic [DATA_W-1:0] item;
	} spmq_entry_t;

endpackage
`default_nettype wire

[hw/rtl/spmq_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none
module spmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/spmq_front.sv]
// Front end: takes input beats, range-checks and classifies them.
`default_nettype none
module spmq_front import spmq_pkg::*; #(
	parameter int LEVELS = 8
) (
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [15:0]       s_tdata,
	input  wire logic [CMD_W-1:0]  s_tuser,
	input  wire logic [CFG_W-1:0]  levels_in_use,
	input  wire logic              q_full,
	output logic                   push,
	output spmq_entry_t            push_entry
);

	logic [LVL_W-1:0]  lvl;
	logic [DATA_W-1:0] itm;
	logic              in_range;

	assign lvl = s_tdata[LVL_W-1:0];
	assign itm = s_tdata[LVL_W +: DATA_W];

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		in_range         = ({1'b0, lvl} < levels_in_use) && (int'(lvl) < LEVELS);
		push_entry.level = lvl;
		push_entry.item  = itm;
		unique case (s_tuser)
			CMD_ENQ:  push_entry.op = in_range ? OP_ENQ : OP_REJECT;
			CMD_DEQ:  push_entry.op = OP_DEQ;
			CMD_PEEK: push_entry.op = in_range ? OP_PEEK : OP_REJECT;
			default: begin
				// unused command: rejected, reported at level zero
				push_entry.op    = OP_REJECT;
				push_entry.level = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

[hw/rtl/spmq_fifo.sv]
// Two-entry queue of classified operations between front and back.
`default_nettype none
module spmq_fifo import spmq_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire spmq_entry_t  push_entry,
	input  wire logic         pop,
	output spmq_entry_t       pop_entry,
	output logic              full,
	output logic              empty
);

	spmq_entry_t mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign empty     = (cnt_q == 2'd0);
	assign pop_entry = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/spmq_back.sv]
// Back end: level lists, node store, free list and the result register.
`default_nettype none
module spmq_back import spmq_pkg::*; #(
	parameter int LEVELS    = 8,
	parameter int NODES     = 64,
	parameter int ITEM_BITS = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CFG_W-1:0] levels_in_use,
	input  wire logic             q_empty,
	input  wire spmq_entry_t      q_entry,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [15:0]           m_tdata,
	output logic [ST_W-1:0]       m_tuser
);

	localparam int LVW  = $clog2(LEVELS);
	localparam int NIDX = $clog2(NODES);
	localparam int CW   = $clog2(NODES + 1);

	typedef enum logic [1:0] {
		BK_ISSUE = 2'b01,
		BK_EXEC  = 2'b10
	} bk_state_t;

	bk_state_t state_q;

	// list state
	logic [NIDX-1:0]  head_q [LEVELS];
	logic [NIDX-1:0]  tail_q [LEVELS];
	logic [LEVELS-1:0] nonempty_q;
	logic [CW-1:0]    fresh_q;
	logic [CW-1:0]    free_cnt_q;
	logic [NIDX-1:0]  free_head_q;

	// operation in flight
	op_t              op_q;
	logic [ST_W-1:0]  stat_q;
	logic [LVW-1:0]   lvl_q;
	logic [LVL_W-1:0] olvl_q;
	logic [NIDX-1:0]  node_q;
	logic             from_free_q;
	logic [ITEM_BITS-1:0] item_q;

	// result register
	logic              m_valid_q;
	logic [ST_W-1:0]   m_stat_q;
	logic [DATA_W-1:0] m_item_q;
	logic [LVL_W-1:0]  m_lvl_q;

	// issue decode
	logic              issue;
	logic [LEVELS-1:0] deq_mask;
	logic              deq_found;
	logic [LVW-1:0]    deq_lvl;
	logic [LVW-1:0]    ent_lvl;
	logic [LVW-1:0]    hd_idx;
	logic [NIDX-1:0]   hd_node;
	logic [ST_W-1:0]   iss_stat;
	logic [LVW-1:0]    iss_lvl;
	logic [LVL_W-1:0]  iss_olvl;
	logic [NIDX-1:0]   iss_node;
	logic              iss_from_free;

	// memory ports
	logic                 item_rd_en;
	logic [ITEM_BITS-1:0] item_rd;
	logic                 item_wr_en;
	logic                 next_rd_en;
	logic [NIDX-1:0]      next_rd_addr;
	logic [NIDX-1:0]      next_rd;
	logic                 next_wr_en;
	logic [NIDX-1:0]      next_wr_addr;
	logic [NIDX-1:0]      next_wr_data;

	logic                 commit;
	logic                 ok_q;
	logic [DATA_W-1:0]    res_item;

	assign issue   = (state_q == BK_ISSUE) && !q_empty;
	assign q_pop   = issue;
	assign commit  = (state_q == BK_EXEC) && (!m_valid_q || m_tready);
	assign ok_q    = (stat_q == ST_OK);
	assign ent_lvl = LVW'(q_entry.level);

	// lowest-numbered non-empty level under the limit
	always_comb begin
		deq_lvl = '0;
		for (int i = 0; i < LEVELS; i++) begin
			deq_mask[i] = nonempty_q[i] && (i < int'(levels_in_use));
		end
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (deq_mask[i]) begin
				deq_lvl = LVW'(i);
			end
		end
		deq_found = |deq_mask;
	end

	assign hd_idx  = (q_entry.op == OP_DEQ) ? deq_lvl : ent_lvl;
	assign hd_node = head_q[hd_idx];

	always_comb begin
		iss_stat      = ST_RANGE;
		iss_lvl       = ent_lvl;
		iss_olvl      = q_entry.level;
		iss_node      = hd_node;
		iss_from_free = 1'b0;
		item_rd_en    = 1'b0;
		next_rd_en    = 1'b0;
		next_rd_addr  = hd_node;
		case (q_entry.op)
			OP_ENQ: begin
				if (free_cnt_q != '0) begin
					iss_stat      = ST_OK;
					iss_node      = free_head_q;
					iss_from_free = 1'b1;
					next_rd_en    = issue;
					next_rd_addr  = free_head_q;
				end else if (fresh_q != CW'(NODES)) begin
					iss_stat = ST_OK;
					iss_node = NIDX'(fresh_q);
				end else begin
					iss_stat = ST_FULL;
				end
			end
			OP_DEQ: begin
				iss_lvl = deq_lvl;
				if (deq_found) begin
					iss_stat   = ST_OK;
					iss_olvl   = LVL_W'(deq_lvl);
					item_rd_en = issue;
					next_rd_en = issue;
				end else begin
					iss_stat = ST_EMPTY;
					iss_olvl = '0;
				end
			end
			OP_PEEK: begin
				if (nonempty_q[ent_lvl]) begin
					iss_stat   = ST_OK;
					item_rd_en = issue;
				end else begin
					iss_stat = ST_EMPTY;
				end
			end
			default: iss_stat = ST_RANGE;
		endcase
	end

	// commit-side writes
	always_comb begin
		item_wr_en   = commit && (op_q == OP_ENQ) && ok_q;
		next_wr_en   = 1'b0;
		next_wr_addr = node_q;
		next_wr_data = free_head_q;
		if (commit && ok_q && (op_q == OP_ENQ) && nonempty_q[lvl_q]) begin
			next_wr_en   = 1'b1;
			next_wr_addr = tail_q[lvl_q];
			next_wr_data = node_q;
		end else if (commit && ok_q && (op_q == OP_DEQ)) begin
			// freed node links onto the free list
			next_wr_en = 1'b1;
		end
	end

	always_comb begin
		res_item = '0;
		if (ok_q) begin
			res_item = (op_q == OP_ENQ) ? DATA_W'(item_q) : DATA_W'(item_rd);
		end
	end

	spmq_ram #(.WIDTH(ITEM_BITS), .DEPTH(NODES)) u_item_ram (
		.clk     (clk),
		.wr_en   (item_wr_en),
		.wr_addr (node_q),
		.wr_data (item_q),
		.rd_en   (item_rd_en),
		.rd_addr (hd_node),
		.rd_data (item_rd)
	);

	spmq_ram #(.WIDTH(NIDX), .DEPTH(NODES)) u_next_ram (
		.clk     (clk),
		.wr_en   (next_wr_en),
		.wr_addr (next_wr_addr),
		.wr_data (next_wr_data),
		.rd_en   (next_rd_en),
		.rd_addr (next_rd_addr),
		.rd_data (next_rd)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (issue) begin
			op_q        <= q_entry.op;
			stat_q      <= iss_stat;
			lvl_q       <= iss_lvl;
			olvl_q      <= iss_olvl;
			node_q      <= iss_node;
			from_free_q <= iss_from_free;
			item_q      <= ITEM_BITS'(q_entry.item);
		end
		if (commit) begin
			m_stat_q <= stat_q;
			m_item_q <= res_item;
			m_lvl_q  <= olvl_q;
			if (ok_q && (op_q == OP_ENQ)) begin
				tail_q[lvl_q] <= node_q;
				if (!nonempty_q[lvl_q]) begin
					head_q[lvl_q] <= node_q;
				end
				if (from_free_q) begin
					free_head_q <= next_rd;
				end
			end
			if (ok_q && (op_q == OP_DEQ)) begin
				head_q[lvl_q] <= next_rd;
				free_head_q   <= node_q;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_ISSUE;
			nonempty_q <= '0;
			fresh_q    <= '0;
			free_cnt_q <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				BK_ISSUE: if (issue) state_q <= BK_EXEC;
				BK_EXEC:  if (commit) state_q <= BK_ISSUE;
				default:  state_q <= BK_ISSUE;
			endcase
			if (commit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (commit && ok_q && (op_q == OP_ENQ)) begin
				nonempty_q[lvl_q] <= 1'b1;
				if (from_free_q) begin
					free_cnt_q <= free_cnt_q - CW'(1);
				end else begin
					fresh_q <= fresh_q + CW'(1);
				end
			end
			if (commit && ok_q && (op_q == OP_DEQ)) begin
				free_cnt_q <= free_cnt_q + CW'(1);
				// popped node was the tail: the level is now empty
				if (node_q == tail_q[lvl_q]) begin
					nonempty_q[lvl_q] <= 1'b0;
				end
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_stat_q;
	assign m_tdata  = {{(16 - DATA_W - LVL_W){1'b0}}, m_lvl_q, m_item_q};

endmodule
`default_nettype wire

[hw/rtl/strict_priority_multilevel_queue.sv]
// Top level of the strict-priority multilevel queue with its register port.
`default_nettype none
// Strict-priority queue of LEVELS FIFO levels sharing one store of NODES nodes. Each input
// beat carries a command in s_tuser (enqueue, dequeue highest priority, peek a level) and
// returns exactly one result beat, in order, with a status in m_tuser (ok, empty, store
// full, level out of range). A dequeue serves the lowest-numbered non-empty level below
// min(levels_in_use, LEVELS); levels at or above a lowered limit keep their items. Freed
// nodes go to a free list and are reused; never-used nodes are handed out by a counter,
// so the store needs no clearing pass after reset. The front end range-checks and
// classifies beats into a two-entry queue, so input is taken while the back end works
// or while a result waits in the output register. The back end handles each command in
// an issue state, which reads the node memories (registered read), and an exec state,
// which commits the list updates and loads the result, and takes no new command until
// that commit; the commit waits while an earlier result is still not accepted.
// Register 0 (byte address 0): levels_in_use, 4 bits, reset 8; write only when idle.
module strict_priority_multilevel_queue import spmq_pkg::*; #(
	parameter int LEVELS    = 8,
	parameter int NODES     = 64,
	parameter int ITEM_BITS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input beats
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [15:0]       s_tdata,   // [2:0] level, [10:3] item, rest zero
	input  wire logic [CMD_W-1:0]  s_tuser,   // [1:0] command
	// result beats
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [15:0]            m_tdata,   // [7:0] out_item, [10:8] out_level, rest zero
	output logic [ST_W-1:0]        m_tuser,   // [1:0] status
	// register port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam logic [2:0] ADDR_LEVELS = 3'd0;

	logic [CFG_W-1:0] levels_q;
	logic             cfg_wr;

	spmq_entry_t push_entry;
	spmq_entry_t pop_entry;
	logic        push;
	logic        pop;
	logic        q_full;
	logic        q_empty;

	// register port: always ready, one register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_LEVELS);
	assign prdata = (paddr == ADDR_LEVELS) ? {{(32 - CFG_W){1'b0}}, levels_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= LEVELS_RESET;
		end else if (cfg_wr) begin
			levels_q <= pwdata[CFG_W-1:0];
		end
	end

	spmq_front #(.LEVELS(LEVELS)) u_front (
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.levels_in_use (levels_q),
		.q_full        (q_full),
		.push          (push),
		.push_entry    (push_entry)
	);

	spmq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.full       (q_full),
		.empty      (q_empty)
	);

	spmq_back #(
		.LEVELS    (LEVELS),
		.NODES     (NODES),
		.ITEM_BITS (ITEM_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.levels_in_use (levels_q),
		.q_empty       (q_empty),
		.q_entry       (pop_entry),
		.q_pop         (pop),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser)
	);

	// queue can never be full and empty at once
	a_q_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("command queue full and empty together");

	// any non-ok result carries a zero item
	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[DATA_W-1:0] == '0))
		else $error("error result with nonzero item");

	// a register write lands in the limit register
	a_cfg_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (levels_q == $past(pwdata[CFG_W-1:0])))
		else $error("levels_in_use write lost");

	// a popped command is never taken from an empty queue
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty command queue");

endmodule
`default_nettype wire
